FILE: design/tre_pkg.sv
// ----------------------------------------------------------------------------
// Trace ring package
// Types, codes and constants shared by the trace ring event writer modules.
// ----------------------------------------------------------------------------
package tre_pkg;

  // Ring geometry; the word count must be a power of two.
  localparam int RING_WORDS = 1024;
  localparam int RING_AW    = $clog2(RING_WORDS);

  // Header layout: length, runtime flag, message type, event id.
  localparam int LEN_W     = 10;
  localparam int LEN_LSB   = 54;
  localparam int RT_BIT    = 53;
  localparam int TYPE_LSB  = 49;
  localparam int HDR_WORDS = 2;
  localparam int MAX_LEN   = (1 << LEN_W) - 1;

  // Width that holds an event length plus padding without overflow.
  localparam int CALC_W = ((LEN_W > RING_AW) ? LEN_W : RING_AW) + 2;

  typedef logic [RING_AW-1:0] ring_addr_t;
  typedef logic [CALC_W-1:0]  calc_t;
  typedef logic [LEN_W-1:0]   len_t;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_REC_OFF  = 2'd2,
    STAT_NO_EVENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP_CHK,
    S_DROP_WAIT,
    S_WR_PAD,
    S_WR_HDR,
    S_WR_TS,
    S_FINISH
  } state_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic        valid;
    logic        is_read;
    status_t     status;
    logic [63:0] head;
    logic [63:0] tail;
  } res_t;

  // Combinational access request to the ring memory.
  typedef struct packed {
    logic        we;
    ring_addr_t  waddr;
    logic [63:0] wdata;
    logic        re;
    ring_addr_t  raddr;
  } mem_req_t;

endpackage

FILE: design/tre_if.sv
// ----------------------------------------------------------------------------
// Trace ring channels
// Valid/ready channels for event items, results and the recording register.
// ----------------------------------------------------------------------------

// Event item channel.
interface tre_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        is_runtime;
  logic [3:0]  msg_type;
  logic [12:0] ev_ident;
  logic [9:0]  payload_len;
  logic [63:0] timestamp;
  logic [63:0] data;
  logic [9:0]  read_addr;

  modport source (output valid, cmd, is_runtime, msg_type, ev_ident, payload_len,
                  timestamp, data, read_addr, input ready);
  modport sink (input valid, cmd, is_runtime, msg_type, ev_ident, payload_len,
                timestamp, data, read_addr, output ready);
endinterface

// Result channel.
interface tre_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] head_index;
  logic [63:0] tail_index;
  logic [63:0] read_data;

  modport source (output valid, status, head_index, tail_index, read_data,
                  input ready);
  modport sink (input valid, status, head_index, tail_index, read_data,
                output ready);
endinterface

// Recording enable register write channel.
interface tre_cfg_if;
  logic valid;
  logic ready;
  logic recording_on;

  modport source (output valid, recording_on, input ready);
  modport sink (input valid, recording_on, output ready);
endinterface

FILE: design/tre_ram.sv
// ----------------------------------------------------------------------------
// Trace ring memory
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tre_seq.sv
// ----------------------------------------------------------------------------
// Trace ring sequencer
// Decodes event items, drops the oldest events by walking their headers,
// writes padding, header, timestamp and payload words and keeps the ring indexes.
// ----------------------------------------------------------------------------
module tre_seq (
  input  logic              clk,
  input  logic              rst,
  tre_req_if.sink           req,
  input  logic              recording_on,
  input  logic              res_take,
  input  logic [63:0]       mem_rdata,
  output tre_pkg::res_t     res,
  output tre_pkg::mem_req_t mem_req
);

  tre_pkg::state_t     state, state_next;

  // Ring indexes and open event bookkeeping.
  logic [63:0]         head_count, head_count_next;
  logic [63:0]         tail_count, tail_count_next;
  tre_pkg::ring_addr_t write_offset, write_offset_next;
  tre_pkg::len_t       words_pending, words_pending_next;
  logic [63:0]         pending_tail, pending_tail_next;

  // Captured begin beat.
  tre_pkg::len_t       len_r;
  tre_pkg::calc_t      pad_r;
  tre_pkg::calc_t      need_r;
  logic                is_runtime_r;
  logic [3:0]          msg_type_r;
  logic [12:0]         ev_ident_r;
  logic [63:0]         timestamp_r;
  tre_pkg::status_t    status_r, status_next;
  logic                is_read_r, is_read_next;

  // Begin beat length and padding, worked out from the current tail.
  tre_pkg::calc_t      acc_len;
  tre_pkg::ring_addr_t acc_off;
  tre_pkg::calc_t      acc_dist;
  tre_pkg::calc_t      acc_pad;
  tre_pkg::calc_t      acc_need;
  logic                acc_too_long;
  logic                accept;

  // Drop walk terms.
  logic [63:0]         occ;
  logic                drop_needed;
  tre_pkg::len_t       hdr_len;
  logic                hdr_bad;

  assign accept = req.valid && req.ready;

  always_comb begin
    acc_len  = tre_pkg::calc_t'(req.payload_len) + tre_pkg::calc_t'(tre_pkg::HDR_WORDS);
    acc_off  = tail_count[tre_pkg::RING_AW-1:0];
    acc_dist = tre_pkg::calc_t'(tre_pkg::RING_WORDS) - tre_pkg::calc_t'(acc_off);
    acc_pad  = (acc_dist < acc_len) ? acc_dist : '0;
    acc_need = acc_len + acc_pad;
    acc_too_long = (acc_len > tre_pkg::calc_t'(tre_pkg::MAX_LEN)) ||
                   (acc_need >= tre_pkg::calc_t'(tre_pkg::RING_WORDS));
  end

  // The ring is too full while occupancy plus the new event reaches its size.
  assign occ         = tail_count - head_count;
  assign drop_needed = (occ + 64'(need_r)) >= 64'(tre_pkg::RING_WORDS);
  assign hdr_len     = mem_rdata[63:tre_pkg::LEN_LSB];
  assign hdr_bad     = (hdr_len == '0) || (64'(hdr_len) > occ);

  // State register and index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tre_pkg::S_IDLE;
      head_count    <= '0;
      tail_count    <= '0;
      write_offset  <= '0;
      words_pending <= '0;
      pending_tail  <= '0;
    end else begin
      state         <= state_next;
      head_count    <= head_count_next;
      tail_count    <= tail_count_next;
      write_offset  <= write_offset_next;
      words_pending <= words_pending_next;
      pending_tail  <= pending_tail_next;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    status_r  <= status_next;
    is_read_r <= is_read_next;
    if (accept) begin
      len_r        <= acc_len[tre_pkg::LEN_W-1:0];
      pad_r        <= acc_pad;
      need_r       <= acc_need;
      is_runtime_r <= req.is_runtime;
      msg_type_r   <= req.msg_type;
      ev_ident_r   <= req.ev_ident;
      timestamp_r  <= req.timestamp;
    end
  end

  // Next state, memory accesses and index updates.
  always_comb begin
    state_next         = state;
    head_count_next    = head_count;
    tail_count_next    = tail_count;
    write_offset_next  = write_offset;
    words_pending_next = words_pending;
    pending_tail_next  = pending_tail;
    status_next        = status_r;
    is_read_next       = is_read_r;
    mem_req            = '0;
    req.ready          = (state == tre_pkg::S_IDLE);
    res.valid          = 1'b0;
    res.is_read        = is_read_r;
    res.status         = status_r;
    res.head           = head_count;
    res.tail           = tail_count;

    case (state)
      tre_pkg::S_IDLE: begin
        if (req.valid) begin
          is_read_next = (tre_pkg::cmd_t'(req.cmd) == tre_pkg::CMD_READ);
          status_next  = tre_pkg::STAT_OK;
          state_next   = tre_pkg::S_FINISH;
          case (tre_pkg::cmd_t'(req.cmd))
            tre_pkg::CMD_BEGIN: begin
              if (!recording_on) begin
                status_next = tre_pkg::STAT_REC_OFF;
              end else if (acc_too_long) begin
                status_next = tre_pkg::STAT_TOO_LONG;
              end else begin
                state_next = tre_pkg::S_DROP_CHK;
              end
            end
            tre_pkg::CMD_PAYLOAD: begin
              if (!recording_on) begin
                status_next = tre_pkg::STAT_REC_OFF;
              end else if (words_pending == '0) begin
                status_next = tre_pkg::STAT_NO_EVENT;
              end else begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = write_offset;
                mem_req.wdata      = req.data;
                write_offset_next  = write_offset + tre_pkg::ring_addr_t'(1);
                words_pending_next = words_pending - tre_pkg::len_t'(1);
                if (words_pending == tre_pkg::len_t'(1)) begin
                  tail_count_next = pending_tail;
                end
              end
            end
            tre_pkg::CMD_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = tre_pkg::ring_addr_t'(req.read_addr);
            end
            default: begin
            end
          endcase
        end
      end

      // Read the oldest header while the new event would lap the head.
      tre_pkg::S_DROP_CHK: begin
        if (drop_needed) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = head_count[tre_pkg::RING_AW-1:0];
          state_next    = tre_pkg::S_DROP_WAIT;
        end else if (pad_r != '0) begin
          state_next = tre_pkg::S_WR_PAD;
        end else begin
          state_next = tre_pkg::S_WR_HDR;
        end
      end

      // A corrupt header empties the ring; otherwise skip the oldest event.
      tre_pkg::S_DROP_WAIT: begin
        head_count_next = hdr_bad ? tail_count : head_count + 64'(hdr_len);
        state_next      = tre_pkg::S_DROP_CHK;
      end

      tre_pkg::S_WR_PAD: begin
        mem_req.we      = 1'b1;
        mem_req.waddr   = tail_count[tre_pkg::RING_AW-1:0];
        mem_req.wdata   = 64'(pad_r) << tre_pkg::LEN_LSB;
        tail_count_next = tail_count + 64'(pad_r);
        state_next      = tre_pkg::S_WR_HDR;
      end

      tre_pkg::S_WR_HDR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = tail_count[tre_pkg::RING_AW-1:0];
        mem_req.wdata = (64'(len_r) << tre_pkg::LEN_LSB) |
                        (64'(is_runtime_r) << tre_pkg::RT_BIT) |
                        (64'(msg_type_r) << tre_pkg::TYPE_LSB) |
                        64'(ev_ident_r);
        state_next    = tre_pkg::S_WR_TS;
      end

      // Timestamp word; an event without payload is published at once.
      tre_pkg::S_WR_TS: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = tail_count[tre_pkg::RING_AW-1:0] + tre_pkg::ring_addr_t'(1);
        mem_req.wdata      = timestamp_r;
        write_offset_next  = tail_count[tre_pkg::RING_AW-1:0] + tre_pkg::ring_addr_t'(2);
        words_pending_next = len_r - tre_pkg::len_t'(tre_pkg::HDR_WORDS);
        pending_tail_next  = tail_count + 64'(len_r);
        if (len_r == tre_pkg::len_t'(tre_pkg::HDR_WORDS)) begin
          tail_count_next = tail_count + 64'(len_r);
        end
        state_next = tre_pkg::S_FINISH;
      end

      tre_pkg::S_FINISH: begin
        res.valid = 1'b1;
        if (res_take) begin
          state_next = tre_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tre_pkg::S_IDLE;
      end
    endcase
  end

  // The head never passes the tail.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head_count <= tail_count)
    else $error("head index passed tail index");

  // Occupancy always stays below the ring size.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    (tail_count - head_count) < 64'(tre_pkg::RING_WORDS))
    else $error("ring occupancy reached the ring size");

  // A header is only walked while the ring holds something.
  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == tre_pkg::S_DROP_WAIT |-> head_count != tail_count)
    else $error("drop walk on an empty ring");

  // The tail moves only on padding, a published event or a final payload beat.
  a_tail_stable: assert property (@(posedge clk) disable iff (rst)
    (state == tre_pkg::S_DROP_CHK || state == tre_pkg::S_DROP_WAIT ||
     state == tre_pkg::S_WR_HDR || state == tre_pkg::S_FINISH) |=> $stable(tail_count))
    else $error("tail index moved outside a write step");

endmodule

FILE: design/trace_ring_event_writer.sv
// ----------------------------------------------------------------------------
// Trace ring event writer
// Single-producer overwriting trace ring with padding and oldest-event drop.
// ----------------------------------------------------------------------------
// One item is worked on at a time and every item gives one result beat. A
// payload beat, a ring read, a no-operation or a refused begin goes from its
// accept cycle straight to the step that loads the result register. An
// accepted begin first checks for drops, reads and decodes the oldest header
// once per dropped event, writes a padding header when the event would run
// past the end of the ring, and writes the header and timestamp words before
// it loads the result register; these steps are set by the single write port
// and the single read port of the ring memory. The next item is taken while a
// result still waits in the output register. The ring memory is not cleared
// after reset: reading an unwritten word returns an undefined value.
// ----------------------------------------------------------------------------
module trace_ring_event_writer (
  input  logic     clk,
  input  logic     rst,
  tre_req_if.sink  req,
  tre_rsp_if.source rsp,
  tre_cfg_if.sink  cfg
);

  logic              recording_on;
  logic              res_take;
  tre_pkg::res_t     res;
  tre_pkg::mem_req_t mem_req;
  logic [63:0]       mem_rdata;

  // Recording enable register; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      recording_on <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      recording_on <= cfg.recording_on;
    end
  end

  // The sequencer may hand over a result when the output register is free.
  assign res_take = !rsp.valid || rsp.ready;

  tre_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .recording_on (recording_on),
    .res_take     (res_take),
    .mem_rdata    (mem_rdata),
    .res          (res),
    .mem_req      (mem_req)
  );

  tre_ram #(
    .WIDTH (64),
    .DEPTH (tre_pkg::RING_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res.valid && res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Output register payload; read data is zero except for a ring read.
  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      rsp.status     <= res.status;
      rsp.head_index <= res.head;
      rsp.tail_index <= res.tail;
      rsp.read_data  <= res.is_read ? mem_rdata : 64'd0;
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Trace ring event writer testbench
// Drives event, payload, read and idle beats into the trace ring writer with
// random gaps and stalls, predicts every result beat from its own copy of the
// ring, its indexes and the recording register, and compares them field by
// field. A short table of directed beats runs first; random beats follow.
// ----------------------------------------------------------------------------
module tb_top;
  import tre_pkg::*;

  // One beat on the event channel.
  typedef struct packed {
    cmd_t        cmd;
    logic        is_runtime;
    logic [3:0]  msg_type;
    logic [12:0] ev_ident;
    logic [9:0]  payload_len;
    logic [63:0] timestamp;
    logic [63:0] data;
    logic [9:0]  read_addr;
  } ev_beat_t;

  // One beat on the result channel.
  typedef struct packed {
    status_t     status;
    logic [63:0] head;
    logic [63:0] tail;
    logic [63:0] rdata;
  } ring_report_t;

  // Directed row: either a register write or an event beat, with the result
  // typed in where it is obvious.
  typedef struct packed {
    logic         cfg_row;
    logic         rec_val;
    ev_beat_t     beat;
    logic         typed;
    ring_report_t want;
  } dir_row_t;

  localparam logic [63:0]  ONES      = '1;
  localparam logic [63:0]  HDR_ROW9  = 64'h00BE_0000_0000_1FFF;
  localparam ev_beat_t     IDLE_BEAT = '{CMD_NOP, 1'b0, 4'd0, 13'd0, 10'd0, 64'd0, 64'd0,
                                         10'd0};
  localparam ring_report_t NO_CHECK  = '{STAT_OK, 64'd0, 64'd0, 64'd0};
  localparam int           DIR_ROWS  = 27;
  // Recording setting of each random phase; phase two runs with recording off.
  localparam bit [5:0]     PHASE_REC = 6'b111011;

  logic clk = 1'b0;
  logic rst;

  tre_req_if req ();
  tre_rsp_if rsp ();
  tre_cfg_if cfg ();

  trace_ring_event_writer dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #6 clk = ~clk;

  // Predicted state of the ring.
  logic [63:0] ring_img [RING_WORDS];
  logic [63:0] head_ix     = 64'd0;
  logic [63:0] tail_ix     = 64'd0;
  ring_addr_t  wr_ptr      = '0;
  logic [9:0]  words_left  = 10'd0;
  logic [63:0] event_end   = 64'd0;
  logic        rec_on      = 1'b0;
  bit          written [RING_WORDS];
  ring_addr_t  written_addrs [$];

  ring_report_t ring_reports_q [$];
  int mismatches  = 0;
  int stim_count  = 0;
  int phase_sent  = 0;
  int quiet_left  = 0;
  int rsp_stall   = 0;
  int rsp_span    = 0;
  bit rsp_steady  = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // Recording off after reset: begin and payload are dropped.
    '{1'b1, 1'b0, IDLE_BEAT, 1'b0, NO_CHECK},
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b1, 4'hF, 13'h1FFF, 10'd1023, ONES, ONES, 10'h3FF},
      1'b1, '{STAT_REC_OFF, 64'd0, 64'd0, 64'd0}},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b1, 4'hF, 13'h1FFF, 10'd5, ONES, ONES, 10'h3FF},
      1'b1, '{STAT_REC_OFF, 64'd0, 64'd0, 64'd0}},
    '{1'b0, 1'b0, IDLE_BEAT, 1'b1, '{STAT_OK, 64'd0, 64'd0, 64'd0}},
    '{1'b1, 1'b1, IDLE_BEAT, 1'b0, NO_CHECK},
    // Payload with no open event, then events too long for the length field.
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'h1234, 10'd0},
      1'b1, '{STAT_NO_EVENT, 64'd0, 64'd0, 64'd0}},
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b0, 4'h3, 13'h0155, 10'd1023, 64'd7, 64'd0, 10'd0},
      1'b1, '{STAT_TOO_LONG, 64'd0, 64'd0, 64'd0}},
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b1, 4'hC, 13'h0AAA, 10'd1022, 64'd9, 64'd0, 10'd0},
      1'b1, '{STAT_TOO_LONG, 64'd0, 64'd0, 64'd0}},
    // Header-only event with every header field at its top value.
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b1, 4'hF, 13'h1FFF, 10'd0, ONES, 64'd0, 10'd0},
      1'b1, '{STAT_OK, 64'd0, 64'd2, 64'd0}},
    '{1'b0, 1'b0, '{CMD_READ, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd0, 10'd0},
      1'b1, '{STAT_OK, 64'd0, 64'd2, HDR_ROW9}},
    '{1'b0, 1'b0, '{CMD_READ, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd0, 10'd1},
      1'b1, '{STAT_OK, 64'd0, 64'd2, ONES}},
    // Event with three payload words; the tail moves only after the last payload beat.
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b0, 4'h0, 13'h0, 10'd3, 64'd0, 64'd0, 10'd0},
      1'b1, '{STAT_OK, 64'd0, 64'd2, 64'd0}},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, ONES, 10'd0},
      1'b1, '{STAT_OK, 64'd0, 64'd2, 64'd0}},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd0, 10'd0},
      1'b1, '{STAT_OK, 64'd0, 64'd2, 64'd0}},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'hA5A5_A5A5_5A5A_5A5A,
      10'd0}, 1'b1, '{STAT_OK, 64'd0, 64'd7, 64'd0}},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd1, 10'd0},
      1'b1, '{STAT_NO_EVENT, 64'd0, 64'd7, 64'd0}},
    // Event left unfinished and abandoned by the next begin.
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b0, 4'h6, 13'h0042, 10'd2, 64'd11, 64'd0, 10'd0},
      1'b1, '{STAT_OK, 64'd0, 64'd7, 64'd0}},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'hDEAD_BEEF, 10'd0},
      1'b1, '{STAT_OK, 64'd0, 64'd7, 64'd0}},
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b1, 4'h5, 13'h0F0F, 10'd0, 64'h0123_4567_89AB_CDEF, 64'd0,
      10'd0}, 1'b1, '{STAT_OK, 64'd0, 64'd9, 64'd0}},
    '{1'b0, 1'b0, '{CMD_READ, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd0, 10'd7},
      1'b0, NO_CHECK},
    '{1'b0, 1'b0, '{CMD_READ, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd0, 10'd4},
      1'b0, NO_CHECK},
    // Largest length that fits the field, refused because of the padding.
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b0, 4'h1, 13'h0001, 10'd1021, 64'd3, 64'd0, 10'd0},
      1'b1, '{STAT_TOO_LONG, 64'd0, 64'd9, 64'd0}},
    '{1'b0, 1'b0, '{CMD_BEGIN, 1'b0, 4'h2, 13'h0002, 10'd900, 64'd4, 64'd0, 10'd0},
      1'b0, NO_CHECK},
    // Recording switched off in the middle of an event, then back on.
    '{1'b1, 1'b0, IDLE_BEAT, 1'b0, NO_CHECK},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd5, 10'd0},
      1'b1, '{STAT_REC_OFF, 64'd0, 64'd9, 64'd0}},
    '{1'b1, 1'b1, IDLE_BEAT, 1'b0, NO_CHECK},
    '{1'b0, 1'b0, '{CMD_PAYLOAD, 1'b0, 4'h0, 13'h0, 10'd0, 64'd0, 64'd6, 10'd0},
      1'b0, NO_CHECK}
  };

  // Store one ring word and remember that it now holds a defined value.
  function automatic void ring_put(ring_addr_t a, logic [63:0] w);
    ring_img[a] = w;
    if (!written[a]) begin
      written[a] = 1'b1;
      written_addrs.push_back(a);
    end
  endfunction

  // Advance the predicted ring by one accepted beat and give its result.
  task automatic ring_apply(input ev_beat_t b, output ring_report_t r);
    logic [63:0] len;
    logic [63:0] off;
    logic [63:0] to_end;
    logic [63:0] pad;
    logic [63:0] hlen;
    r = NO_CHECK;
    case (b.cmd)
      CMD_BEGIN: begin
        if (!rec_on) begin
          r.status = STAT_REC_OFF;
        end else begin
          len    = 64'(b.payload_len) + HDR_WORDS;
          off    = 64'(tail_ix[RING_AW-1:0]);
          to_end = RING_WORDS - off;
          pad    = (to_end < len) ? to_end : 64'd0;
          if (len > MAX_LEN || len + pad >= RING_WORDS) begin
            r.status = STAT_TOO_LONG;
          end else begin
            // Retire the oldest events until the new one and its padding fit.
            while (tail_ix + len + pad - head_ix >= RING_WORDS) begin
              hlen = ring_img[head_ix[RING_AW-1:0]] >> LEN_LSB;
              if (hlen == 0 || hlen > tail_ix - head_ix) head_ix = tail_ix;
              else head_ix = head_ix + hlen;
            end
            if (pad != 0) begin
              ring_put(ring_addr_t'(off), pad << LEN_LSB);
              tail_ix = tail_ix + pad;
              off     = 64'd0;
            end
            ring_put(ring_addr_t'(off), (len << LEN_LSB) | (64'(b.is_runtime) << RT_BIT) |
                     (64'(b.msg_type) << TYPE_LSB) | 64'(b.ev_ident));
            ring_put(ring_addr_t'(off + 1), b.timestamp);
            wr_ptr     = ring_addr_t'(off + 2);
            words_left = b.payload_len;
            event_end  = tail_ix + len;
            if (words_left == 0) tail_ix = event_end;
          end
        end
      end
      CMD_PAYLOAD: begin
        if (!rec_on) begin
          r.status = STAT_REC_OFF;
        end else if (words_left == 0) begin
          r.status = STAT_NO_EVENT;
        end else begin
          ring_put(wr_ptr, b.data);
          wr_ptr     = wr_ptr + 1'b1;
          words_left = words_left - 1'b1;
          if (words_left == 0) tail_ix = event_end;
        end
      end
      CMD_READ: begin
        r.rdata = ring_img[ring_addr_t'(b.read_addr)];
      end
      default: begin
      end
    endcase
    r.head = head_ix;
    r.tail = tail_ix;
  endtask

  // Mostly short idle stretches, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random beat of the given kind; reads only hit words already written.
  function automatic ev_beat_t rand_beat(cmd_t c, int plen);
    ev_beat_t b;
    b.cmd         = c;
    b.is_runtime  = 1'($urandom_range(0, 1));
    b.msg_type    = 4'($urandom);
    b.ev_ident    = 13'($urandom);
    b.payload_len = 10'(plen);
    b.timestamp   = {$urandom, $urandom};
    b.data        = {$urandom, $urandom};
    b.read_addr   = 10'($urandom);
    if (c == CMD_READ) begin
      if (written_addrs.size() == 0) b.cmd = CMD_NOP;
      else b.read_addr = 10'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
    end
    return b;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Send one event beat, sometimes after a random gap, and record what it should return.
  task automatic send_beat(input ev_beat_t b, input logic typed, input ring_report_t want);
    int gap;
    ring_report_t r;
    gap = 0;
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 99) >= 55) gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.cmd         <= b.cmd;
    req.is_runtime  <= b.is_runtime;
    req.msg_type    <= b.msg_type;
    req.ev_ident    <= b.ev_ident;
    req.payload_len <= b.payload_len;
    req.timestamp   <= b.timestamp;
    req.data        <= b.data;
    req.read_addr   <= b.read_addr;
    req.valid       <= 1'b1;
    do @(posedge clk); while (req.ready !== 1'b1);
    if (rec_on || b.cmd == CMD_READ || b.cmd == CMD_NOP) stim_count++;
    phase_sent++;
    ring_apply(b, r);
    ring_reports_q.push_back(typed ? want : r);
  endtask

  task automatic send_rand(input cmd_t c, input int plen);
    send_beat(rand_beat(c, plen), 1'b0, NO_CHECK);
  endtask

  // Hold the event channel until every awaited result beat has arrived.
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (ring_reports_q.size() != 0);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_recording(input logic on);
    wait_drained();
    cfg.recording_on <= on;
    cfg.valid        <= 1'b1;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    rec_on = on;
    cfg.valid <= 1'b0;
  endtask

  // Result receiver: random stalls, with steady stretches in between.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp.ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp.ready <= 1'b1;
      if (!rsp_steady && $urandom_range(0, 99) < 25) rsp_stall <= gap_len();
    end
    if (rsp_span > 0) begin
      rsp_span <= rsp_span - 1;
    end else begin
      rsp_steady <= ($urandom_range(0, 99) < 30);
      rsp_span   <= $urandom_range(50, 400);
    end
  end

  // Compare each result beat with the oldest awaited one.
  always @(posedge clk) begin
    ring_report_t want;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (ring_reports_q.size() == 0) begin
        flag_mismatch("result beat with nothing awaited");
      end else begin
        want = ring_reports_q.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch($sformatf("status %0d, awaited %0d", rsp.status, want.status));
        if (rsp.head_index !== want.head)
          flag_mismatch($sformatf("head_index %0h, awaited %0h", rsp.head_index, want.head));
        if (rsp.tail_index !== want.tail)
          flag_mismatch($sformatf("tail_index %0h, awaited %0h", rsp.tail_index, want.tail));
        if (rsp.read_data !== want.rdata)
          flag_mismatch($sformatf("read_data %0h, awaited %0h", rsp.read_data, want.rdata));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    int roll;
    int pick;
    int plen;
    int cut;
    int phase_base;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.cmd          = CMD_NOP;
    req.is_runtime   = 1'b0;
    req.msg_type     = 4'd0;
    req.ev_ident     = 13'd0;
    req.payload_len  = 10'd0;
    req.timestamp    = 64'd0;
    req.data         = 64'd0;
    req.read_addr    = 10'd0;
    cfg.valid        = 1'b0;
    cfg.recording_on = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_row) set_recording(dir_tab[i].rec_val);
      else send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_recording(PHASE_REC[ph]);
      phase_base = stim_count;
      phase_sent = 0;
      while (rec_on ? (stim_count - phase_base < 240) : (phase_sent < 40)) begin
        roll = $urandom_range(0, 99);
        if (quiet_left == 0 && $urandom_range(0, 99) < 10) quiet_left = $urandom_range(20, 80);
        if (roll < 55) begin
          // Complete event: begin beat, then exactly its payload beats, now and then a read between.
          pick = $urandom_range(0, 99);
          plen = (pick < 80) ? $urandom_range(0, 6) :
                 (pick < 96) ? $urandom_range(7, 40) : $urandom_range(41, 250);
          send_rand(CMD_BEGIN, plen);
          for (int k = 0; k < plen; k++) begin
            if ($urandom_range(0, 99) < 5) send_rand(CMD_READ, 0);
            send_rand(CMD_PAYLOAD, $urandom_range(0, 1023));
          end
        end else if (roll < 67) begin
          // Event cut short; the next begin abandons it.
          plen = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 1021) : $urandom_range(1, 40);
          send_rand(CMD_BEGIN, plen);
          cut = $urandom_range(0, (plen > 20) ? 20 : plen - 1);
          for (int k = 0; k < cut; k++) send_rand(CMD_PAYLOAD, 0);
        end else if (roll < 73) begin
          // Very long begin: refused, or accepted and forcing many old events out.
          send_rand(CMD_BEGIN, $urandom_range(600, 1023));
        end else if (roll < 86) begin
          send_rand(CMD_READ, 0);
        end else if (roll < 92) begin
          send_rand(CMD_PAYLOAD, $urandom_range(0, 1023));
        end else if (roll < 97) begin
          send_rand(CMD_NOP, $urandom_range(0, 1023));
        end else begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit: far above the slowest legal run, where every beat meets the
  // longest gap, the longest stall and a begin that retires a full ring.
  initial begin
    #100000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
